// File: src/cbop_pkg.sv
// ----------------------------------------------------------------------------
// cbop_pkg
// shared constants and types for the circle versus box overlap push pipeline
// ----------------------------------------------------------------------------
package cbop_pkg;

    localparam int COORD_BITS = 24;

    typedef struct packed {
        logic hit;
        logic in_box;
        logic neg_x;
        logic neg_y;
    } cbop_flags_t;

endpackage

// File: src/cbop_front.sv
// ----------------------------------------------------------------------------
// cbop_front
// clamps the centre to the box, takes the offsets, squares them and compares
// the squared distance with the squared radius over four register stages
// ----------------------------------------------------------------------------
module cbop_front
    import cbop_pkg::*;
#(
    parameter int CB = COORD_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [CB-1:0]       centre_x,
    input  logic [CB-1:0]       centre_y,
    input  logic [CB-2:0]       radius,
    input  logic [CB-1:0]       box_left,
    input  logic [CB-1:0]       box_top,
    input  logic [CB-2:0]       box_width,
    input  logic [CB-2:0]       box_height,
    output logic                out_valid,
    output logic [2*CB-3:0]     dsq,
    output logic [CB-2:0]       ax,
    output logic [CB-2:0]       ay,
    output logic [CB-2:0]       rad,
    output cbop_flags_t         flags
);

    localparam int N = CB - 1;

    logic [3:0] v_reg;

    // stage 1
    logic [CB-1:0] cx1_reg, cy1_reg, l1_reg, t1_reg;
    logic [CB:0]   rt1_reg, bt1_reg;
    logic [N-1:0]  r1_reg;

    // stage 2
    logic [N-1:0]  ax2_reg, ay2_reg, r2_reg;
    logic          near2_reg, sx2_reg, sy2_reg;
    logic [CB:0]   dlx, dly;
    logic [CB+1:0] drx, dry;
    logic [CB:0]   magx, magy;
    logic          nearx, neary;

    // stage 3
    logic [2*N-1:0] sqx3_reg, sqy3_reg, rr3_reg;
    logic [N-1:0]   ax3_reg, ay3_reg, r3_reg;
    logic           near3_reg, sx3_reg, sy3_reg;

    // stage 4
    logic [2*N-1:0] dsq4_reg;
    logic [N-1:0]   ax4_reg, ay4_reg, r4_reg;
    cbop_flags_t    flags4_reg;
    logic [2*N:0]   sum;
    logic           hit4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        cx1_reg <= centre_x;
        cy1_reg <= centre_y;
        l1_reg  <= box_left;
        t1_reg  <= box_top;
        rt1_reg <= {box_left[CB-1], box_left} + {2'b00, box_width};
        bt1_reg <= {box_top[CB-1], box_top} + {2'b00, box_height};
        r1_reg  <= radius;
    end

    always_comb
    begin
        dlx = {cx1_reg[CB-1], cx1_reg} - {l1_reg[CB-1], l1_reg};
        dly = {cy1_reg[CB-1], cy1_reg} - {t1_reg[CB-1], t1_reg};
        drx = {{2{cx1_reg[CB-1]}}, cx1_reg} - {rt1_reg[CB], rt1_reg};
        dry = {{2{cy1_reg[CB-1]}}, cy1_reg} - {bt1_reg[CB], bt1_reg};
        if (dlx[CB])
        begin
            magx = -dlx;
        end
        else if (!drx[CB+1] && (drx != '0))
        begin
            magx = drx[CB:0];
        end
        else
        begin
            magx = '0;
        end
        if (dly[CB])
        begin
            magy = -dly;
        end
        else if (!dry[CB+1] && (dry != '0))
        begin
            magy = dry[CB:0];
        end
        else
        begin
            magy = '0;
        end
        nearx = magx <= {2'b00, r1_reg};
        neary = magy <= {2'b00, r1_reg};
    end

    always_ff @(posedge clk)
    begin
        ax2_reg   <= nearx ? magx[N-1:0] : '0;
        ay2_reg   <= neary ? magy[N-1:0] : '0;
        near2_reg <= nearx && neary;
        sx2_reg   <= dlx[CB];
        sy2_reg   <= dly[CB];
        r2_reg    <= r1_reg;
    end

    always_ff @(posedge clk)
    begin
        sqx3_reg  <= ax2_reg * ax2_reg;
        sqy3_reg  <= ay2_reg * ay2_reg;
        rr3_reg   <= r2_reg * r2_reg;
        ax3_reg   <= ax2_reg;
        ay3_reg   <= ay2_reg;
        r3_reg    <= r2_reg;
        near3_reg <= near2_reg;
        sx3_reg   <= sx2_reg;
        sy3_reg   <= sy2_reg;
    end

    assign sum  = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
    assign hit4 = near3_reg && (sum <= {1'b0, rr3_reg});

    always_ff @(posedge clk)
    begin
        dsq4_reg          <= hit4 ? sum[2*N-1:0] : '0;
        ax4_reg           <= ax3_reg;
        ay4_reg           <= ay3_reg;
        r4_reg            <= r3_reg;
        flags4_reg.hit    <= hit4;
        flags4_reg.in_box <= hit4 && (sum == '0);
        flags4_reg.neg_x  <= sx3_reg;
        flags4_reg.neg_y  <= sy3_reg;
    end

    assign out_valid = v_reg[3];
    assign dsq       = dsq4_reg;
    assign ax        = ax4_reg;
    assign ay        = ay4_reg;
    assign rad       = r4_reg;
    assign flags     = flags4_reg;

endmodule

// File: src/cbop_sqrt.sv
// ----------------------------------------------------------------------------
// cbop_sqrt
// pipelined integer square root, one root bit per stage, with remainder
// ----------------------------------------------------------------------------
module cbop_sqrt
    import cbop_pkg::*;
#(
    parameter int N  = COORD_BITS - 1,
    parameter int SW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2*N-1:0]   radicand,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [N-1:0]     root,
    output logic [N+1:0]     rem,
    output logic [SW-1:0]    side_out
);

    logic [N-1:0]   v_reg;
    logic [N+1:0]   rem_reg  [N];
    logic [N-1:0]   root_reg [N];
    logic [2*N-1:0] rad_reg  [N];
    logic [SW-1:0]  side_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N+1:0]   rem_prev;
        logic [N-1:0]   root_prev;
        logic [2*N-1:0] rad_prev;
        logic [SW-1:0]  side_prev;
        logic [N+1:0]   shifted;
        logic [N+1:0]   trial;
        logic           take;

        if (k == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = radicand;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign shifted = {rem_prev[N-1:0], rad_prev[2*N-1 -: 2]};
        assign trial   = {root_prev, 2'b01};
        assign take    = shifted >= trial;

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? (shifted - trial) : shifted;
            root_reg[k] <= {root_prev[N-2:0], take};
            rad_reg[k]  <= {rad_prev[2*N-3:0], 2'b00};
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = root_reg[N-1];
    assign rem       = rem_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// File: src/cbop_div.sv
// ----------------------------------------------------------------------------
// cbop_div
// pipelined restoring divider, one quotient bit per stage; the quotient
// must fit in n bits
// ----------------------------------------------------------------------------
module cbop_div
    import cbop_pkg::*;
#(
    parameter int N  = COORD_BITS - 1,
    parameter int SW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2*N:0]     num,
    input  logic [N-1:0]     den,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [N-1:0]     quot,
    output logic [SW-1:0]    side_out
);

    logic [N-1:0]  v_reg;
    logic [N:0]    rem_reg  [N];
    logic [N-1:0]  low_reg  [N];
    logic [N-1:0]  q_reg    [N];
    logic [N-1:0]  den_reg  [N];
    logic [SW-1:0] side_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N:0]    rem_prev;
        logic [N-1:0]  low_prev;
        logic [N-1:0]  q_prev;
        logic [N-1:0]  den_prev;
        logic [SW-1:0] side_prev;
        logic [N:0]    trial;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_prev  = num[2*N:N];
            assign low_prev  = num[N-1:0];
            assign q_prev    = '0;
            assign den_prev  = den;
            assign side_prev = side_in;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign low_prev  = low_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial = {rem_prev[N-1:0], low_prev[N-1]};
        assign take  = trial >= {1'b0, den_prev};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? (trial - {1'b0, den_prev}) : trial;
            low_reg[k]  <= {low_prev[N-2:0], 1'b0};
            q_reg[k]    <= {q_prev[N-2:0], take};
            den_reg[k]  <= den_prev;
            side_reg[k] <= side_prev;
        end
    end

    assign out_valid = v_reg[N-1];
    assign quot      = q_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// File: src/circle_box_overlap_push_core.sv
// ----------------------------------------------------------------------------
// circle_box_overlap_push_core
// circle versus axis-aligned box overlap test with separating push vector
// throughput: one word per cycle; busy is always low, the receiver cannot stall
// the root and the two dividers retire one bit per stage, which sets the depth
// reset clears only the valid bits; no word is in flight after reset
// ----------------------------------------------------------------------------
module circle_box_overlap_push_core
    import cbop_pkg::*;
#(
    parameter int COORD_BITS = cbop_pkg::COORD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_BITS-1:0]  centre_x,
    input  logic [COORD_BITS-1:0]  centre_y,
    input  logic [COORD_BITS-2:0]  radius,
    input  logic [COORD_BITS-1:0]  box_left,
    input  logic [COORD_BITS-1:0]  box_top,
    input  logic [COORD_BITS-2:0]  box_width,
    input  logic [COORD_BITS-2:0]  box_height,
    output logic                   done,
    output logic                   hit,
    output logic                   centre_inside,
    output logic [COORD_BITS-1:0]  push_x,
    output logic [COORD_BITS-1:0]  push_y
);

    localparam int CB = COORD_BITS;
    localparam int N  = CB - 1;
    localparam int SW = 3 * N + 4;

    logic             f_valid;
    logic [2*N-1:0]   f_dsq;
    logic [N-1:0]     f_ax, f_ay, f_r;
    cbop_flags_t      f_flags;

    logic             q_valid;
    logic [N-1:0]     q_root;
    logic [N+1:0]     q_rem;
    logic [SW-1:0]    q_side;
    logic [N-1:0]     q_ax, q_ay, q_r;
    cbop_flags_t      q_flags;
    logic [N-1:0]     s_round;

    logic [2:0]       v_reg;
    logic [N-1:0]     sa_reg, pen_reg, axa_reg, aya_reg;
    cbop_flags_t      fa_reg;
    logic [2*N-1:0]   px_reg, py_reg;
    logic [N-1:0]     sb_reg;
    cbop_flags_t      fb_reg;
    logic [2*N:0]     nx_reg, ny_reg;
    logic [N-1:0]     sc_reg;
    cbop_flags_t      fc_reg;

    logic             dx_valid, dy_valid;
    logic [N-1:0]     qx, qy;
    cbop_flags_t      dx_flags;
    logic             dy_neg;
    logic             emit;
    logic [CB-1:0]    magx, magy;

    logic             done_reg, hit_reg, inside_reg;
    logic [CB-1:0]    push_x_reg, push_y_reg;

    assign busy = 1'b0;

    cbop_front #(.CB(CB)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .centre_x   (centre_x),
        .centre_y   (centre_y),
        .radius     (radius),
        .box_left   (box_left),
        .box_top    (box_top),
        .box_width  (box_width),
        .box_height (box_height),
        .out_valid  (f_valid),
        .dsq        (f_dsq),
        .ax         (f_ax),
        .ay         (f_ay),
        .rad        (f_r),
        .flags      (f_flags)
    );

    cbop_sqrt #(.N(N), .SW(SW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .radicand  (f_dsq),
        .side_in   ({f_r, f_ax, f_ay, f_flags}),
        .out_valid (q_valid),
        .root      (q_root),
        .rem       (q_rem),
        .side_out  (q_side)
    );

    assign {q_r, q_ax, q_ay, q_flags} = q_side;

    // round to nearest, ties up
    assign s_round = q_root + N'(q_rem > {2'b00, q_root});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg  <= s_round;
        pen_reg <= q_r - s_round;
        axa_reg <= q_ax;
        aya_reg <= q_ay;
        fa_reg  <= q_flags;
        px_reg  <= axa_reg * pen_reg;
        py_reg  <= aya_reg * pen_reg;
        sb_reg  <= sa_reg;
        fb_reg  <= fa_reg;
        nx_reg  <= {1'b0, px_reg} + {{(N+2){1'b0}}, sb_reg[N-1:1]};
        ny_reg  <= {1'b0, py_reg} + {{(N+2){1'b0}}, sb_reg[N-1:1]};
        sc_reg  <= sb_reg;
        fc_reg  <= fb_reg;
    end

    cbop_div #(.N(N), .SW(4)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[2]),
        .num       (nx_reg),
        .den       (sc_reg),
        .side_in   (fc_reg),
        .out_valid (dx_valid),
        .quot      (qx),
        .side_out  (dx_flags)
    );

    cbop_div #(.N(N), .SW(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg[2]),
        .num       (ny_reg),
        .den       (sc_reg),
        .side_in   (fc_reg.neg_y),
        .out_valid (dy_valid),
        .quot      (qy),
        .side_out  (dy_neg)
    );

    assign emit = dx_flags.hit && !dx_flags.in_box;
    assign magx = {1'b0, qx};
    assign magy = {1'b0, qy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dx_valid && dy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= dx_flags.hit;
        inside_reg <= dx_flags.in_box;
        push_x_reg <= emit ? (dx_flags.neg_x ? -magx : magx) : '0;
        push_y_reg <= emit ? (dy_neg ? -magy : magy) : '0;
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign centre_inside = inside_reg;
    assign push_x        = push_x_reg;
    assign push_y        = push_y_reg;

endmodule
